@@ rtl/rc4_pkg.sv @@
// Shared types and constants for the RC4 stream cipher block.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
`default_nettype none

package rc4_pkg;

   localparam int TABLE_SIZE    = 256;
   localparam int TABLE_AW      = 8;
   localparam int BYTE_W        = 8;
   localparam int MAX_KEY_BYTES = 256;
   localparam int KEY_CNT_W     = 9;

   typedef logic [BYTE_W-1:0]    data_type;
   typedef logic [TABLE_AW-1:0]  addr_type;
   typedef logic [KEY_CNT_W-1:0] key_cnt_type;

   // Kinds of input word, carried on tuser.
   localparam logic OPER_KEY  = 1'b0;
   localparam logic OPER_DATA = 1'b1;

   // Datapath operations, one per controller step.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT_WR,
      OP_KS_RD_N,
      OP_KS_RD_J,
      OP_KS_WR_N,
      OP_KS_WR_J,
      OP_G_RD_I,
      OP_G_RD_J,
      OP_G_WR_I,
      OP_G_WR_J,
      OP_G_RD_T
   } dp_op_type;

   typedef struct packed {
      logic      key_load;
      logic      key_close;
      logic      data_load;
      logic      out_load;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic key_ready;
      logic n_last;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ rtl/rc4_ctrl.sv @@
// Sequencing state machine of the RC4 block: key schedule and keystream steps.
// Depends on rc4_pkg; drives the datapath rc4_dp through command and status structs.
`default_nettype none

module rc4_ctrl import rc4_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_oper,
   input  logic        req_last,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [11:0] {
      S_IDLE    = 12'h001,
      S_INIT    = 12'h002,
      S_KS_RD_N = 12'h004,
      S_KS_RD_J = 12'h008,
      S_KS_WR_N = 12'h010,
      S_KS_WR_J = 12'h020,
      S_G_RD_I  = 12'h040,
      S_G_RD_J  = 12'h080,
      S_G_WR_I  = 12'h100,
      S_G_WR_J  = 12'h200,
      S_G_RD_T  = 12'h400,
      S_RESULT  = 12'h800
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      cmd.key_load  = accept && (req_oper == OPER_KEY);
      cmd.key_close = req_last;
      cmd.data_load = accept && (req_oper == OPER_DATA);
      cmd.out_load  = 1'b0;
      cmd.op        = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_oper == OPER_KEY) begin
                  if (req_last) state_in = S_INIT;
               end else begin
                  state_in = stat.key_ready ? S_G_RD_I : S_RESULT;
               end
            end
         end
         S_INIT: begin
            cmd.op = OP_INIT_WR;
            if (stat.n_last) state_in = S_KS_RD_N;
         end
         S_KS_RD_N: begin
            cmd.op   = OP_KS_RD_N;
            state_in = S_KS_RD_J;
         end
         S_KS_RD_J: begin
            cmd.op   = OP_KS_RD_J;
            state_in = S_KS_WR_N;
         end
         S_KS_WR_N: begin
            cmd.op   = OP_KS_WR_N;
            state_in = S_KS_WR_J;
         end
         S_KS_WR_J: begin
            cmd.op   = OP_KS_WR_J;
            state_in = stat.n_last ? S_IDLE : S_KS_RD_N;
         end
         S_G_RD_I: begin
            cmd.op   = OP_G_RD_I;
            state_in = S_G_RD_J;
         end
         S_G_RD_J: begin
            cmd.op   = OP_G_RD_J;
            state_in = S_G_WR_I;
         end
         S_G_WR_I: begin
            cmd.op   = OP_G_WR_I;
            state_in = S_G_WR_J;
         end
         S_G_WR_J: begin
            cmd.op   = OP_G_WR_J;
            state_in = S_G_RD_T;
         end
         S_G_RD_T: begin
            cmd.op   = OP_G_RD_T;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

@@ rtl/rc4_dp.sv @@
// Datapath of the RC4 block: permutation table, key store, indices and output register.
// Depends on rc4_pkg; commanded by rc4_ctrl.
`default_nettype none

module rc4_dp import rc4_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  data_type    req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output data_type    rsp_data,
   output logic        rsp_keyed
);

   data_type    perm_mem [TABLE_SIZE];
   data_type    key_mem  [MAX_KEY_BYTES];
   data_type    perm_rd_ff, key_rd_ff;

   addr_type    n_ff, n_in, jj_ff, jj_in, kidx_ff, kidx_in;
   addr_type    i_ff, i_in, j_ff, j_in;
   data_type    sa_ff, sa_in, sb_ff, sb_in, data_ff, data_in;
   key_cnt_type key_count_ff, key_count_in, key_base;
   logic        key_ready_ff, key_ready_in, key_open_ff, key_open_in;
   logic        rsp_valid_ff, rsp_valid_in, rsp_keyed_ff, rsp_keyed_in;
   data_type    rsp_data_ff, rsp_data_in;

   logic        key_room, kidx_wrap, key_wr, sched_end;
   addr_type    jj_next, j_next, i_next;
   logic        rd_en, wr_en;
   addr_type    rd_addr, wr_addr;
   data_type    wr_data;

   assign key_base  = key_open_ff ? key_count_ff : '0;
   assign key_room  = key_base < KEY_CNT_W'(MAX_KEY_BYTES);
   assign key_wr    = cmd.key_load && key_room;
   assign jj_next   = jj_ff + perm_rd_ff + key_rd_ff;
   assign j_next    = j_ff + perm_rd_ff;
   assign i_next    = i_ff + 1'b1;
   assign kidx_wrap = ({1'b0, kidx_ff} + 1'b1) == key_count_ff;
   assign sched_end = (cmd.op == OP_KS_WR_J) && stat.n_last;

   assign stat.key_ready = key_ready_ff;
   assign stat.n_last    = (n_ff == TABLE_AW'(TABLE_SIZE - 1));
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // Table port selection: one read and one write address per cycle.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = n_ff;
      wr_en   = 1'b0;
      wr_addr = n_ff;
      wr_data = n_ff;
      case (cmd.op)
         OP_INIT_WR: wr_en = 1'b1;
         OP_KS_RD_N: rd_en = 1'b1;
         OP_KS_RD_J: begin
            rd_en   = 1'b1;
            rd_addr = jj_next;
         end
         OP_KS_WR_N: begin
            wr_en   = 1'b1;
            wr_data = perm_rd_ff;
         end
         OP_KS_WR_J: begin
            wr_en   = 1'b1;
            wr_addr = jj_ff;
            wr_data = sa_ff;
         end
         OP_G_RD_I: begin
            rd_en   = 1'b1;
            rd_addr = i_next;
         end
         OP_G_RD_J: begin
            rd_en   = 1'b1;
            rd_addr = j_next;
         end
         OP_G_WR_I: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = perm_rd_ff;
         end
         OP_G_WR_J: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = sa_ff;
         end
         OP_G_RD_T: begin
            rd_en   = 1'b1;
            rd_addr = sa_ff + sb_ff;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) perm_mem[wr_addr] <= wr_data;
      if (rd_en) perm_rd_ff <= perm_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (key_wr) key_mem[key_base[TABLE_AW-1:0]] <= req_data;
      if (cmd.op == OP_KS_RD_N) key_rd_ff <= key_mem[kidx_ff];
   end

   always_comb begin
      n_in         = n_ff;
      jj_in        = jj_ff;
      kidx_in      = kidx_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      data_in      = data_ff;
      key_count_in = key_count_ff;
      key_open_in  = key_open_ff;
      key_ready_in = key_ready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_keyed_in = rsp_keyed_ff;

      if (cmd.key_load) begin
         key_count_in = key_room ? key_base + 1'b1 : key_base;
         key_open_in  = !cmd.key_close;
         key_ready_in = 1'b0;
         if (cmd.key_close) begin
            n_in    = '0;
            jj_in   = '0;
            kidx_in = '0;
         end
      end
      if (cmd.data_load) data_in = req_data;

      if ((cmd.op == OP_INIT_WR) || (cmd.op == OP_KS_WR_J)) n_in = n_ff + 1'b1;
      if (cmd.op == OP_KS_RD_J) jj_in = jj_next;
      if (cmd.op == OP_KS_WR_J) kidx_in = kidx_wrap ? '0 : kidx_ff + 1'b1;
      if ((cmd.op == OP_KS_RD_J) || (cmd.op == OP_G_RD_J)) sa_in = perm_rd_ff;
      if (cmd.op == OP_G_WR_I) sb_in = perm_rd_ff;
      if (cmd.op == OP_G_RD_I) i_in = i_next;
      if (cmd.op == OP_G_RD_J) j_in = j_next;
      if (sched_end) begin
         i_in         = '0;
         j_in         = '0;
         key_ready_in = 1'b1;
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_keyed_in = key_ready_ff;
         rsp_data_in  = key_ready_ff ? (data_ff ^ perm_rd_ff) : data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         key_count_ff <= '0;
         key_open_ff  <= 1'b0;
         key_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         i_ff         <= i_in;
         j_ff         <= j_in;
         key_count_ff <= key_count_in;
         key_open_ff  <= key_open_in;
         key_ready_ff <= key_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      jj_ff        <= jj_in;
      kidx_ff      <= kidx_in;
      sa_ff        <= sa_in;
      sb_ff        <= sb_in;
      data_ff      <= data_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_keyed_ff <= rsp_keyed_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_keyed = rsp_keyed_ff;

endmodule

`default_nettype wire

@@ rtl/rc4_stream_cipher.sv @@
// Top level of the RC4 stream cipher: joins the controller and the datapath.
// Depends on rc4_pkg, rc4_ctrl and rc4_dp.
//
// Usage. Words enter on the req_ stream. A key word has tuser = 0 and carries one
// key byte in tdata; tlast marks the final key byte. Keys are 1 to 256 bytes long;
// further bytes are dropped, but their tlast still ends the key. A data word has
// tuser = 1 and returns one rsp_ word holding the byte XORed with the next keystream
// byte, with tuser = 1. Data sent before any key, or while a new key is loading,
// comes back unchanged with tuser = 0.
// Operation. The block works on one word at a time in a single-port permutation table.
// A key byte without tlast leaves the block ready for the next word. The final key
// byte starts the schedule: it fills the identity table, then does each swap as a read
// of s[n], a read of s[j] and two writes; req_tready stays low throughout. A keyed data
// word steps through read s[i], read s[j], two swap writes, keystream read and result
// load before the next word is taken; an unkeyed word only does the result load.
// The result sits in an output register, so a key word is accepted while a result
// still waits. When the receiver stalls, a data word finishes its work and holds
// in the result step until the output register frees; the rsp_ word stays stable.
// Reset clears the indices i and j, the key state and the output valid; the table and key
// store need no clearing, since they are always written before they are read.
`default_nettype none

module rc4_stream_cipher import rc4_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  data_type req_tdata,   // [7:0] data_byte
   input  logic     req_tuser,   // [0] operation
   input  logic     req_tlast,   // key_last
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output data_type rsp_tdata,   // [7:0] out_byte
   output logic     rsp_tuser    // [0] keyed
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // The controller owns all sequencing; it also decides when a word is taken.
   rc4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_oper  (req_tuser),
      .req_last  (req_tlast),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds the table, the key store and the output register.
   rc4_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_tdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata),
      .rsp_keyed (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ rtl/rc4_checker.sv @@
// Port-level checker for rc4_stream_cipher, attached by the bind at the end.
// Depends on rc4_pkg and the top level's port list.
`default_nettype none

module rc4_port_checker import rc4_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_tvalid,
   input logic     req_tready,
   input logic     req_tuser,
   input logic     req_tlast,
   input logic     rsp_tvalid,
   input logic     rsp_tready,
   input data_type rsp_tdata,
   input logic     rsp_tuser
);

   // A stalled result word holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // No result word right after reset.
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The final key byte starts the schedule, so the block is busy on the next cycle.
   a_sched_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OPER_KEY) && req_tlast |=> !req_tready)
      else $error("ready right after final key byte");

   // A data word is worked alone: no new word is taken the cycle after it.
   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OPER_DATA) |=> !req_tready)
      else $error("ready right after a data word");

endmodule

bind rc4_stream_cipher rc4_port_checker u_rc4_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
